@@ rtl/core/sca_pkg.sv @@
`default_nettype none
package sca_pkg;

	typedef enum logic [2:0] {
		FUNC_NEW    = 3'd0,
		FUNC_SIZE   = 3'd1,
		FUNC_APPEND = 3'd2,
		FUNC_LOCATE = 3'd3,
		FUNC_CLEAR  = 3'd4,
		FUNC_READ   = 3'd5,
		FUNC_WRITE  = 3'd6,
		FUNC_NONE   = 3'd7
	} func_t;

	localparam logic [7:0] ERASED = 8'hFF;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] file_num;
		logic [7:0] chain_position;
		logic       which_table;
		logic [7:0] entry_index;
		logic [7:0] entry_value;
	} cmd_t;

	typedef struct packed {
		logic       status;
		logic [7:0] value;
	} rsp_t;

endpackage
`default_nettype wire

@@ rtl/core/sca_ram.sv @@
`default_nettype none
module sca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/core/sca_ctrl.sv @@
`default_nettype none
module sca_ctrl #(
	parameter int ENTRIES = 256
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire sca_pkg::cmd_t          cmd,
	output logic                        busy,
	output logic                        done,
	output sca_pkg::rsp_t               result,
	output logic                        dir_we,
	output logic [$clog2(ENTRIES)-1:0]  dir_waddr,
	output logic [7:0]                  dir_wdata,
	output logic [$clog2(ENTRIES)-1:0]  dir_raddr,
	input  wire  [7:0]                  dir_rdata,
	output logic                        lnk_we,
	output logic [$clog2(ENTRIES)-1:0]  lnk_waddr,
	output logic [7:0]                  lnk_wdata,
	output logic [$clog2(ENTRIES)-1:0]  lnk_raddr,
	input  wire  [7:0]                  lnk_rdata
);
	import sca_pkg::*;

	localparam int AW = $clog2(ENTRIES);
	localparam logic [8:0] NIL = 9'(ENTRIES - 1);
	localparam logic [7:0] NIL8 = 8'(ENTRIES - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_WIPE, S_NEW, S_DIR, S_WALK, S_FDIR, S_FWALK, S_LOCW, S_RAW, S_DONE
	} state_t;

	state_t     state_q;
	cmd_t       cmd_q;
	logic [8:0] idx_q;     // directory scan / wipe index
	logic [7:0] cur_q;     // current sector
	logic [8:0] cnt_q;     // links followed
	logic [7:0] high_q;
	logic       any_q;
	logic [7:0] fresh_q;
	logic       dir_tgt_q;
	rsp_t       res_q;

	logic dir_end, lnk_end;
	assign dir_end = {1'b0, dir_rdata} >= NIL;
	assign lnk_end = {1'b0, lnk_rdata} >= NIL;

	// Read addresses: driven in the cycle before the data is used.
	always_comb begin
		dir_raddr = AW'(idx_q);
		lnk_raddr = AW'(cur_q);
		dir_we = 1'b0; dir_waddr = AW'(idx_q); dir_wdata = ERASED;
		lnk_we = 1'b0; lnk_waddr = AW'(idx_q); lnk_wdata = ERASED;
		case (state_q)
			S_IDLE: begin
				dir_raddr = start ? AW'(cmd.entry_index) : AW'(idx_q);
				lnk_raddr = AW'(cmd.entry_index);
				if (start && cmd.func == FUNC_NEW) dir_raddr = '0;
				if (start && (cmd.func == FUNC_SIZE || cmd.func == FUNC_LOCATE))
					dir_raddr = AW'(cmd.file_num);
				if (start && cmd.func == FUNC_APPEND) dir_raddr = '0;
			end
			S_WIPE: begin
				dir_we = 1'b1;
				lnk_we = 1'b1;
			end
			S_NEW, S_DIR: begin
				dir_raddr = AW'(idx_q + 9'd1);
				// start the walk at the first sector just read
				lnk_raddr = dir_rdata[AW-1:0];
			end
			S_WALK: begin
				lnk_raddr = lnk_end ? cur_q[AW-1:0] : lnk_rdata[AW-1:0];
				dir_raddr = lnk_end || cnt_q + 9'd1 >= NIL ?
					(dir_tgt_q ? AW'(cmd_q.file_num) : AW'(idx_q + 9'd1))
					: AW'(idx_q);
			end
			S_FDIR, S_FWALK: begin
				lnk_raddr = (state_q == S_FDIR) ? dir_rdata[AW-1:0] :
					(lnk_end ? cur_q[AW-1:0] : lnk_rdata[AW-1:0]);
				if (state_q == S_FDIR && dir_end && cmd_q.func == FUNC_APPEND) begin
					dir_we = 1'b1;
					dir_waddr = AW'(cmd_q.file_num);
					dir_wdata = fresh_q;
				end
				if (state_q == S_FWALK && cmd_q.func == FUNC_APPEND &&
						(lnk_end || cnt_q + 9'd1 >= NIL)) begin
					lnk_we = 1'b1;
					lnk_waddr = lnk_end ? cur_q[AW-1:0] : lnk_rdata[AW-1:0];
					lnk_wdata = fresh_q;
				end
			end
			S_LOCW: lnk_raddr = lnk_rdata[AW-1:0];
			S_RAW: begin
				// fetch the target file's directory entry for append
				if (dir_tgt_q) dir_raddr = AW'(cmd_q.file_num);
			end
			S_DONE: begin
				if (cmd_q.func == FUNC_WRITE && {1'b0, cmd_q.entry_index} < 9'(ENTRIES)) begin
					if (cmd_q.which_table) begin
						lnk_we = 1'b1;
						lnk_waddr = AW'(cmd_q.entry_index);
						lnk_wdata = cmd_q.entry_value;
					end else begin
						dir_we = 1'b1;
						dir_waddr = AW'(cmd_q.entry_index);
						dir_wdata = cmd_q.entry_value;
					end
				end
			end
			default: ;
		endcase
	end

	logic [8:0] fresh_w;
	assign fresh_w = {1'b0, high_q} + 9'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_WIPE;
			idx_q <= '0;
			cur_q <= '0; cnt_q <= '0; high_q <= '0; any_q <= 1'b0;
			fresh_q <= '0; dir_tgt_q <= 1'b0; res_q <= '0; cmd_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						idx_q <= '0; cnt_q <= '0; any_q <= 1'b0; high_q <= '0;
						dir_tgt_q <= 1'b0;
						case (func_t'(cmd.func))
							FUNC_NEW:    state_q <= S_NEW;
							FUNC_SIZE:   state_q <= S_FDIR;
							FUNC_APPEND: state_q <= S_DIR;
							FUNC_LOCATE: state_q <= S_FDIR;
							FUNC_CLEAR: begin
								res_q <= '0; state_q <= S_WIPE;
							end
							FUNC_READ:   state_q <= S_RAW;
							FUNC_WRITE: begin
								res_q <= '0; state_q <= S_DONE;
							end
							default: begin
								res_q <= '{status: 1'b1, value: 8'd0}; state_q <= S_DONE;
							end
						endcase
						if (cmd.func == FUNC_CLEAR) idx_q <= '0;
						if ({1'b0, cmd.file_num} >= 9'(ENTRIES)) begin
							if (cmd.func == FUNC_SIZE) begin
								res_q <= '0; state_q <= S_DONE;
							end else if (cmd.func == FUNC_APPEND || cmd.func == FUNC_LOCATE) begin
								res_q <= '{status: 1'b1, value: NIL8}; state_q <= S_DONE;
							end
						end
						if (cmd.func == FUNC_READ && {1'b0, cmd.entry_index} >= 9'(ENTRIES)) begin
							res_q <= '{status: 1'b1, value: NIL8}; state_q <= S_DONE;
						end
					end
				end
				S_WIPE: begin
					idx_q <= idx_q + 9'd1;
					if (idx_q == NIL) begin
						idx_q <= '0;
						if (cmd_q.func == FUNC_CLEAR) state_q <= S_DONE;
						else state_q <= S_IDLE;
					end
				end
				S_NEW: begin
					if (dir_end) begin
						res_q <= '{status: 1'b0, value: idx_q[7:0]}; state_q <= S_DONE;
					end else if (idx_q + 9'd1 >= NIL) begin
						res_q <= '{status: 1'b1, value: NIL8}; state_q <= S_DONE;
					end
					idx_q <= idx_q + 9'd1;
				end
				S_DIR: begin
					// directory entry idx_q read; dir_raddr was idx_q+1 (unused)
					if (dir_end || idx_q == 9'(ENTRIES)) begin
						if (!any_q) fresh_q <= 8'd0;
						else fresh_q <= 8'(fresh_w);
						if (any_q && fresh_w >= NIL) begin
							res_q <= '{status: 1'b1, value: NIL8}; state_q <= S_DONE;
						end else begin
							state_q <= S_RAW; dir_tgt_q <= 1'b1;
						end
					end else begin
						cur_q <= dir_rdata; cnt_q <= '0; state_q <= S_WALK;
					end
				end
				S_WALK: begin
					// lnk_rdata = next_sector[cur_q]
					if (lnk_end || cnt_q + 9'd1 >= NIL) begin
						high_q <= (!any_q || cur_q > high_q) ? cur_q : high_q;
						any_q <= 1'b1;
						idx_q <= idx_q + 9'd1;
						state_q <= S_DIR;
						if (!lnk_end) begin
							high_q <= (!any_q || lnk_rdata > high_q) ? lnk_rdata : high_q;
						end
					end else begin
						cur_q <= lnk_rdata; cnt_q <= cnt_q + 9'd1;
					end
				end
				S_RAW: begin
					if (dir_tgt_q) begin
						// directory entry of target file is requested this cycle
						state_q <= S_FDIR;
					end else begin
						res_q <= '{status: 1'b0,
							value: cmd_q.which_table ? lnk_rdata : dir_rdata};
						state_q <= S_DONE;
					end
				end
				S_FDIR: begin
					cnt_q <= '0;
					cur_q <= dir_rdata;
					if (dir_end) begin
						if (cmd_q.func == FUNC_SIZE) res_q <= '0;
						else if (cmd_q.func == FUNC_LOCATE) res_q <= '{status: 1'b1, value: NIL8};
						else res_q <= '{status: 1'b0, value: fresh_q};
						state_q <= S_DONE;
					end else if (cmd_q.func == FUNC_LOCATE) begin
						if (cmd_q.chain_position == 8'd0) begin
							res_q <= '{status: 1'b0, value: dir_rdata}; state_q <= S_DONE;
						end else state_q <= S_LOCW;
					end else state_q <= S_FWALK;
				end
				S_FWALK: begin
					if (lnk_end || cnt_q + 9'd1 >= NIL) begin
						if (cmd_q.func == FUNC_SIZE)
							res_q <= '{status: 1'b0, value: 8'(cnt_q + 9'd1)};
						else res_q <= '{status: 1'b0, value: fresh_q};
						if (cmd_q.func == FUNC_APPEND && !lnk_end)
							cur_q <= cur_q;
						state_q <= S_DONE;
					end else begin
						cur_q <= lnk_rdata; cnt_q <= cnt_q + 9'd1;
					end
				end
				S_LOCW: begin
					if (lnk_end) begin
						res_q <= '{status: 1'b1, value: NIL8}; state_q <= S_DONE;
					end else if (cnt_q + 9'd1 == {1'b0, cmd_q.chain_position}) begin
						res_q <= '{status: 1'b0, value: lnk_rdata}; state_q <= S_DONE;
					end else cnt_q <= cnt_q + 9'd1;
				end
				S_DONE: begin
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign result = res_q;
endmodule
`default_nettype wire

@@ rtl/core/sector_chain_allocator_top.sv @@
`default_nettype none
// Sector chain allocator: a directory of first sectors and a link table of
// next sectors, both in single-port-read synchronous RAMs.
// Command channel: drive start with cmd; the command transfers at a rising
// edge with start high and busy low. Exactly one result follows: result is
// valid for the single cycle in which done is high; the receiver cannot
// stall it and must take it then.
// Raw write and unused codes go straight to the result; raw read first passes
// a read state. New file scans the directory, one entry per cycle (up to
// ENTRIES-1). Size and locate walk a chain one link per cycle through the
// link RAM read port (up to ENTRIES-1 links). Append walks every file chain
// up to the first empty directory entry, one link per cycle, with a directory
// step between chains. Clear sweeps both RAMs.
// Reset: the block runs the same sweep after arst_n releases, writing the
// empty mark into every entry; busy stays high until the sweep ends.
// One command at a time: busy drops in the cycle the result is shown, so the
// next command can transfer at the edge that takes the result.
module sector_chain_allocator_top #(
	parameter int ENTRIES = 256
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            start,
	input  wire sca_pkg::cmd_t cmd,
	output logic           busy,
	output logic           done,
	output sca_pkg::rsp_t  result
);
	import sca_pkg::*;
	localparam int AW = $clog2(ENTRIES);

	logic          dir_we, lnk_we;
	logic [AW-1:0] dir_waddr, dir_raddr, lnk_waddr, lnk_raddr;
	logic [7:0]    dir_wdata, dir_rdata, lnk_wdata, lnk_rdata;

	sca_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
		.clk, .arst_n, .start, .cmd, .busy, .done, .result,
		.dir_we, .dir_waddr, .dir_wdata, .dir_raddr, .dir_rdata,
		.lnk_we, .lnk_waddr, .lnk_wdata, .lnk_raddr, .lnk_rdata
	);

	// directory: first sector per file
	sca_ram #(.WIDTH(8), .DEPTH(ENTRIES)) u_dir (
		.clk, .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
		.raddr(dir_raddr), .rdata(dir_rdata)
	);

	// link table: next sector per sector
	sca_ram #(.WIDTH(8), .DEPTH(ENTRIES)) u_lnk (
		.clk, .we(lnk_we), .waddr(lnk_waddr), .wdata(lnk_wdata),
		.raddr(lnk_raddr), .rdata(lnk_rdata)
	);

`ifndef NO_ASSERTIONS
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without command");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result repeated");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !dir_we && !lnk_we) else $error("table write while idle");
`endif
endmodule
`default_nettype wire
